/* design/gwng_pkg.sv */
`default_nettype none

package gwng_pkg;

   // Side of the square grid in cells.
   localparam int GRID_SIDE = 256;
   localparam int IDX_W     = $clog2(GRID_SIDE);
   localparam int BOUND_W   = IDX_W + 1;
   localparam int ADDR_W    = 2 * IDX_W;

   localparam logic [7:0] WIN_HALF_RESET = 8'd24;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_FETCH = 2'd2
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_QROW  = 5'b00010,
      ST_QCOL  = 5'b00100,
      ST_READ  = 5'b01000,
      ST_CHECK = 5'b10000
   } state_type;

   // Clamped window along one axis: lo inclusive, hi exclusive.
   typedef struct packed {
      logic               ok;
      logic [IDX_W-1:0]   lo;
      logic [BOUND_W-1:0] hi;
   } bound_type;

endpackage

`default_nettype wire

/* design/gwng_if.sv */
`default_nettype none

interface gwng_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [7:0]         cell_row;
   logic [7:0]         cell_col;
   logic [15:0]        cell_value;
   logic signed [13:0] point_x;
   logic signed [13:0] point_y;

   modport source (output valid, command, cell_row, cell_col, cell_value, point_x, point_y,
                   input ready);
   modport sink (input valid, command, cell_row, cell_col, cell_value, point_x, point_y,
                 output ready);
endinterface

interface gwng_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit_valid;
   logic [15:0] hit_value;

   modport source (output valid, hit_valid, hit_value, input ready);
   modport sink (input valid, hit_valid, hit_value, output ready);
endinterface

interface gwng_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] window_half;

   modport source (output valid, window_half, input ready);
   modport sink (input valid, window_half, output ready);
endinterface

`default_nettype wire

/* design/gwng_bound.sv */
`default_nettype none

module gwng_bound
   import gwng_pkg::*;
(
   input  wire logic signed [13:0] coord,
   input  wire logic [7:0]         half,
   output bound_type               bound
);

   localparam logic signed [11:0] SIDE_S = 12'(GRID_SIDE);

   logic signed [14:0] biased;
   logic               neg;
   logic [14:0]        mag;
   logic [11:0]        quot;
   logic signed [11:0] idx;
   logic signed [11:0] half_s;
   logic signed [11:0] low_raw;
   logic signed [11:0] high_raw;
   logic signed [11:0] low_clamp;
   logic signed [11:0] high_clamp;

   // Map to a cell of 16 units: add one half, then truncate toward zero.
   always_comb begin
      biased     = {coord[13], coord} + 15'sd8;
      neg        = biased[14];
      mag        = neg ? 15'(-biased) : biased;
      quot       = {2'b00, mag[13:4]};
      idx        = neg ? $signed(12'(-quot)) : $signed(quot);
      half_s     = $signed({4'b0000, half});
      low_raw    = idx - half_s;
      high_raw   = idx + half_s;
      low_clamp  = low_raw[11] ? 12'sd0 : low_raw;
      high_clamp = (high_raw >= SIDE_S) ? SIDE_S : high_raw;
      bound.ok   = low_clamp < high_clamp;
      bound.lo   = low_clamp[IDX_W-1:0];
      bound.hi   = high_clamp[BOUND_W-1:0];
   end

endmodule

`default_nettype wire

/* design/gwng_grid_mem.sv */
`default_nettype none

module gwng_grid_mem
   import gwng_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [15:0]       wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]            rd_data
);

   logic [15:0] cells [GRID_SIDE*GRID_SIDE];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells[wr_addr] <= wr_data;
      end
   end

   // The read data holds until the next read, so a stalled check keeps its cell.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= cells[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* design/grid_window_nonzero_gather_unit.sv */
`default_nettype none

// Grid window gather: a 256 x 256 store of 16-bit cells, where 0 is empty. A write item
// is written to the grid as it is taken. A query item is accepted, then bounded one
// axis at a time, row then column, as the rounding and clamping unit is shared between
// row and column. A fetch item walks the window row-major from where the last fetch
// stopped; each cell examined is first read from memory, then tested in the registered
// read data. Each fetch gives exactly one result: a hit with its value, or a no-hit
// once the window is exhausted or when no scan is active. A result waits in an output
// register, and a new item is taken while it waits; a fetch that finds its result
// while the previous one still waits holds until the register frees. The grid is not
// cleared at reset: cells must be written before they are queried. window_half resets
// to 24.
module grid_window_nonzero_gather_unit
   import gwng_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   gwng_req_if.sink    req_if,
   gwng_rsp_if.source  rsp_if,
   gwng_csr_if.sink    csr_if
);

   state_type          state_ff, state_in;
   logic [7:0]         win_half_ff;
   logic signed [13:0] pt_x_ff, pt_y_ff;
   logic [BOUND_W-1:0] scan_row_ff, scan_row_in;
   logic [BOUND_W-1:0] scan_col_ff, scan_col_in;
   logic [IDX_W-1:0]   col_low_ff, col_low_in;
   logic [BOUND_W-1:0] row_high_ff, row_high_in;
   logic [BOUND_W-1:0] col_high_ff, col_high_in;
   logic               active_ff, active_in;
   logic               row_ok_ff, row_ok_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               hit_valid_ff, hit_valid_in;
   logic [15:0]        hit_value_ff, hit_value_in;

   logic               req_take;
   logic               out_free;
   logic signed [13:0] unit_coord;
   bound_type          unit_bound;
   logic [BOUND_W-1:0] col_next, row_next;
   logic               mem_wr, mem_rd;
   logic [15:0]        mem_data;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.hit_valid = hit_valid_ff;
   assign rsp_if.hit_value = hit_value_ff;

   assign unit_coord = (state_ff == ST_QROW) ? pt_x_ff : pt_y_ff;

   gwng_bound u_bound (
      .coord (unit_coord),
      .half  (win_half_ff),
      .bound (unit_bound)
   );

   assign mem_wr   = req_take && (req_if.command == CMD_WRITE);
   assign mem_rd   = (state_ff == ST_READ) && active_ff;
   assign col_next = scan_col_ff + 1'b1;
   assign row_next = scan_row_ff + 1'b1;

   gwng_grid_mem u_grid (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr ({req_if.cell_row[IDX_W-1:0], req_if.cell_col[IDX_W-1:0]}),
      .wr_data (req_if.cell_value),
      .rd_en   (mem_rd),
      .rd_addr ({scan_row_ff[IDX_W-1:0], scan_col_ff[IDX_W-1:0]}),
      .rd_data (mem_data)
   );

   always_comb begin
      state_in     = state_ff;
      scan_row_in  = scan_row_ff;
      scan_col_in  = scan_col_ff;
      col_low_in   = col_low_ff;
      row_high_in  = row_high_ff;
      col_high_in  = col_high_ff;
      active_in    = active_ff;
      row_ok_in    = row_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      hit_valid_in = hit_valid_ff;
      hit_value_in = hit_value_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_if.command)
                  CMD_QUERY: state_in = ST_QROW;
                  CMD_FETCH: state_in = ST_READ;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_QROW: begin
            // The old scan is dropped as soon as the row bounds are replaced.
            scan_row_in = {1'b0, unit_bound.lo};
            row_high_in = unit_bound.hi;
            row_ok_in   = unit_bound.ok;
            active_in   = 1'b0;
            state_in    = ST_QCOL;
         end
         ST_QCOL: begin
            scan_col_in = {1'b0, unit_bound.lo};
            col_low_in  = unit_bound.lo;
            col_high_in = unit_bound.hi;
            active_in   = row_ok_ff && unit_bound.ok;
            state_in    = ST_IDLE;
         end
         ST_READ: begin
            if (active_ff) begin
               // The pointer moves on before the cell is tested, as the scan resumes
               // after a hit from the following cell.
               if (col_next >= col_high_ff) begin
                  scan_col_in = {1'b0, col_low_ff};
                  scan_row_in = row_next;
                  if (row_next >= row_high_ff) begin
                     active_in = 1'b0;
                  end
               end else begin
                  scan_col_in = col_next;
               end
               state_in = ST_CHECK;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               hit_valid_in = 1'b0;
               hit_value_in = 16'd0;
               state_in     = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (mem_data == 16'd0) begin
               state_in = ST_READ;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               hit_valid_in = 1'b1;
               hit_value_in = mem_data;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_row_ff  <= '0;
         scan_col_ff  <= '0;
         col_low_ff   <= '0;
         row_high_ff  <= '0;
         col_high_ff  <= '0;
         active_ff    <= 1'b0;
         row_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win_half_ff  <= WIN_HALF_RESET;
      end else begin
         state_ff     <= state_in;
         scan_row_ff  <= scan_row_in;
         scan_col_ff  <= scan_col_in;
         col_low_ff   <= col_low_in;
         row_high_ff  <= row_high_in;
         col_high_ff  <= col_high_in;
         active_ff    <= active_in;
         row_ok_ff    <= row_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid) begin
            win_half_ff <= csr_if.window_half;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_valid_ff <= hit_valid_in;
      hit_value_ff <= hit_value_in;
      if (req_take && (req_if.command == CMD_QUERY)) begin
         pt_x_ff <= req_if.point_x;
         pt_y_ff <= req_if.point_y;
      end
   end

   // An active scan always points at a cell inside its window.
   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (scan_row_ff < row_high_ff) && (scan_col_ff < col_high_ff))
      else $error("scan pointer outside the window");

   // A no-hit result carries a zero value, and a hit never carries zero.
   a_hit_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (hit_valid_ff == (hit_value_ff != 16'd0)))
      else $error("hit flag and hit value disagree");

   // A new result only comes out of the fetch walk.
   a_result_from_fetch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_if.ready))
         |-> (state_ff == ST_READ || state_ff == ST_CHECK))
      else $error("result produced outside a fetch");

   // The grid is never read while an item is being taken.
   a_read_not_idle: assert property (@(posedge clock) disable iff (reset)
      mem_rd |-> !req_if.ready)
      else $error("grid read while accepting an item");

endmodule

`default_nettype wire
